FILE: src/lgq_pkg.sv
`timescale 1ns / 1ps

package lgq_pkg;

   localparam int FRAC_BITS = 30;

   // Q30 one at the working widths, and half a Q30 LSB in Q60 for rounding
   localparam logic signed [33:0] L_ONE    = 34'sd1073741824;
   localparam logic signed [31:0] X_ONE    = 32'sd1073741824;
   localparam logic [67:0]        Q_HALF   = 68'd536870912;

   // output limits
   localparam logic signed [33:0] LV_MAX   = 34'sd1073741824;
   localparam logic signed [34:0] QV_MAX   = 35'sd2147483648;
   localparam logic signed [41:0] QS_MAX   = 42'sd69793218560;

   // one point travelling down the recurrence
   typedef struct packed {
      logic signed [31:0] x;
      logic [5:0]         n;
      logic signed [33:0] lm1;   // L(k-2) on entry to step k
      logic signed [33:0] ln;    // L(k-1) on entry to step k
      logic signed [34:0] q;
   } lgq_item_type;

   typedef struct packed {
      logic signed [37:0] q_slope;
      logic signed [32:0] q_value;
      logic signed [31:0] legendre_value;
   } lgq_result_type;

   // round a Q60 product to Q30, to nearest, ties away from zero
   function automatic logic signed [37:0] round_q(input logic signed [67:0] p);
      logic [67:0] mag;
      logic [67:0] r;
      mag = p[67] ? 68'(-p) : 68'(p);
      r   = (mag + Q_HALF) >> FRAC_BITS;
      return p[67] ? -$signed(r[37:0]) : $signed(r[37:0]);
   endfunction

endpackage

FILE: src/lgq_step.sv
`timescale 1ns / 1ps

module lgq_step #(
   parameter int K = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  lgq_pkg::lgq_item_type in_item,
   output logic                 out_valid,
   output lgq_pkg::lgq_item_type out_item
);
   import lgq_pkg::*;

   // a_k = (2k-1)/k and b_k = (k-1)/k in Q30, rounded to nearest
   localparam logic [31:0] A_COEF =
      32'(((64'(2 * K - 1) << 30) + 64'(K / 2)) / 64'(K));
   localparam logic [31:0] B_COEF =
      32'(((64'(K - 1) << 30) + 64'(K / 2)) / 64'(K));
   localparam logic [6:0]  K_CODE = 7'(K);

   logic                 a_valid_ff;
   lgq_item_type         a_item_ff;
   logic signed [33:0]   ax_ff;
   logic signed [33:0]   ax_in;
   logic signed [33:0]   bl_ff;
   logic signed [33:0]   bl_in;
   logic signed [64:0]   prod_ax;
   logic signed [65:0]   prod_bl;

   logic                 b_valid_ff;
   lgq_item_type         b_item_ff;
   lgq_item_type         b_item_in;
   logic signed [67:0]   prod_l;
   logic signed [33:0]   lk;
   logic [6:0]           n_ext;

   // first half: coefficient products
   always_comb begin
      prod_ax = 65'($signed({1'b0, A_COEF})) * 65'(in_item.x);
      prod_bl = 66'($signed({1'b0, B_COEF})) * 66'(in_item.lm1);
      ax_in   = 34'(round_q(68'(prod_ax)));
      bl_in   = 34'(round_q(68'(prod_bl)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_item_ff <= in_item;
         ax_ff     <= ax_in;
         bl_ff     <= bl_in;
      end
   end

   // second half: new L value, then shift, capture q, or pass along
   always_comb begin
      prod_l    = 68'(ax_ff) * 68'(a_item_ff.ln);
      lk        = 34'(round_q(prod_l)) - bl_ff;
      n_ext     = {1'b0, a_item_ff.n};
      b_item_in = a_item_ff;
      if (n_ext >= K_CODE) begin
         b_item_in.lm1 = a_item_ff.ln;
         b_item_in.ln  = lk;
      end else if (n_ext + 7'd1 == K_CODE) begin
         b_item_in.q = 35'(lk) - 35'(a_item_ff.lm1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_item_ff <= b_item_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

endmodule

FILE: src/lgq_finish.sv
`timescale 1ns / 1ps

module lgq_finish (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  lgq_pkg::lgq_item_type  in_item,
   output logic                   out_valid,
   output lgq_pkg::lgq_result_type out_result
);
   import lgq_pkg::*;

   logic                valid_ff;
   lgq_result_type      result_ff;
   lgq_result_type      result_in;
   logic [6:0]          odd_n;
   logic signed [41:0]  slope;
   logic signed [33:0]  lv;
   logic signed [34:0]  qv;
   logic signed [41:0]  qs;

   // the derivative terms cancel down to (2n+1) * L(n)
   always_comb begin
      odd_n = {in_item.n, 1'b1};
      slope = 42'($signed({1'b0, odd_n})) * 42'(in_item.ln);

      if (in_item.ln > LV_MAX) begin
         lv = LV_MAX;
      end else if (in_item.ln < -LV_MAX) begin
         lv = -LV_MAX;
      end else begin
         lv = in_item.ln;
      end

      if (in_item.q > QV_MAX) begin
         qv = QV_MAX;
      end else if (in_item.q < -QV_MAX) begin
         qv = -QV_MAX;
      end else begin
         qv = in_item.q;
      end

      if (slope > QS_MAX) begin
         qs = QS_MAX;
      end else if (slope < -QS_MAX) begin
         qs = -QS_MAX;
      end else begin
         qs = slope;
      end

      result_in.legendre_value = 32'(lv);
      result_in.q_value        = 33'(qv);
      result_in.q_slope        = 38'(qs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

FILE: src/lgq_outbuf.sv
`timescale 1ns / 1ps

module lgq_outbuf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  lgq_pkg::lgq_result_type in_result,
   output logic                    in_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output lgq_pkg::lgq_result_type out_result
);
   import lgq_pkg::*;

   logic           out_valid_ff;
   logic           out_valid_in;
   lgq_result_type out_data_ff;
   lgq_result_type out_data_in;
   logic           skid_valid_ff;
   logic           skid_valid_in;
   lgq_result_type skid_data_ff;
   lgq_result_type skid_data_in;
   logic           push;

   assign in_ready = !skid_valid_ff;
   assign push     = in_valid && !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = in_result;
         end
      end else if (push) begin
         // output is held, park the arriving item
         skid_valid_in = 1'b1;
         skid_data_in  = in_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_data_ff;

endmodule

FILE: src/legendre_q_and_value_eval.sv
`timescale 1ns / 1ps

// path: the input register, both registers of each step, the finish register, the output buffer
// throughput: one item per cycle while the output skid entry is empty; each recurrence
//   step k has its own two-stage multiplier slice; depth follows MAX_DEGREE, not degree
// stalls: a two-entry output buffer lets an item enter while a result waits
// reset: synchronous, clears all valid bits and sets degree to 1
module legendre_q_and_value_eval #(
   parameter int MAX_DEGREE = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [5:0]   csr_wr_data,   // degree
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,     // point
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata      // legendre_value, q_value, q_slope, zero pad
);
   import lgq_pkg::*;

   localparam logic [6:0] MAX_N = 7'(MAX_DEGREE);

   logic [5:0]          degree_ff;
   logic                en;
   logic                in_valid_ff;
   lgq_item_type        in_item_ff;
   lgq_item_type        in_item_in;
   logic signed [31:0]  point;
   logic [5:0]          n_clip;

   logic                stage_valid [MAX_DEGREE + 1];
   lgq_item_type        stage_item  [MAX_DEGREE + 1];

   logic                fin_valid;
   lgq_result_type      fin_result;
   lgq_result_type      rsp_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= 6'd1;
      end else if (csr_wr_en) begin
         degree_ff <= csr_wr_data;
      end
   end

   // clamp the point, clip the degree, seed L0 = 1 and L1 = x
   always_comb begin
      point = $signed(req_tdata);
      if (degree_ff == 6'd0) begin
         n_clip = 6'd1;
      end else if ({1'b0, degree_ff} > MAX_N) begin
         n_clip = MAX_N[5:0];
      end else begin
         n_clip = degree_ff;
      end
      if (point > X_ONE) begin
         in_item_in.x = X_ONE;
      end else if (point < -X_ONE) begin
         in_item_in.x = -X_ONE;
      end else begin
         in_item_in.x = point;
      end
      in_item_in.n   = n_clip;
      in_item_in.lm1 = L_ONE;
      in_item_in.ln  = 34'(in_item_in.x);
      in_item_in.q   = '0;
   end

   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_item_ff <= in_item_in;
      end
   end

   assign stage_valid[0] = in_valid_ff;
   assign stage_item[0]  = in_item_ff;

   for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_step
      lgq_step #(
         .K(i + 2)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (stage_valid[i]),
         .in_item   (stage_item[i]),
         .out_valid (stage_valid[i + 1]),
         .out_item  (stage_item[i + 1])
      );
   end

   lgq_finish u_finish (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (stage_valid[MAX_DEGREE]),
      .in_item    (stage_item[MAX_DEGREE]),
      .out_valid  (fin_valid),
      .out_result (fin_result)
   );

   lgq_outbuf u_outbuf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (fin_valid),
      .in_result  (fin_result),
      .in_ready   (en),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_result)
   );

   assign rsp_tdata = {1'b0, rsp_result.q_slope, rsp_result.q_value,
                       rsp_result.legendre_value};

   // a full skid entry means the output register is occupied
   a_stall_has_output: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("pipeline stalled with no result on the output");

   // a result arriving behind a held output must be parked
   a_park_on_hold: assert property (@(posedge clock) disable iff (reset)
      (fin_valid && en && rsp_tvalid && !rsp_tready) |=> !req_tready)
      else $error("arriving result not parked behind held output");

   // nothing leaves right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

FILE: test/legendre_eval_check.sv
`timescale 1ns / 1ps

module legendre_eval_check #(
   parameter int MAX_DEGREE = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [5:0]   csr_wr_data,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [31:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   output int           fail_count,
   output int           pending
);
   import lgq_pkg::*;

   localparam longint HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);
   localparam longint ONE_Q30  = 64'sd1 <<< FRAC_BITS;

   logic [5:0]     degree_now;
   lgq_result_type predicted_evals[$];

   // product back to q30, nearest, ties away from zero
   function automatic longint rnd_q30(longint p);
      if (p >= 0)
         return (p + HALF_LSB) >>> FRAC_BITS;
      return -((-p + HALF_LSB) >>> FRAC_BITS);
   endfunction

   // q30 coefficient num/k, nearest, ties up
   function automatic longint ratio_q30(longint num, longint k);
      return ((num <<< FRAC_BITS) + k / 2) / k;
   endfunction

   function automatic longint next_legendre(longint k, longint x, longint l1, longint l2);
      return rnd_q30(rnd_q30(ratio_q30(2 * k - 1, k) * x) * l1)
             - rnd_q30(ratio_q30(k - 1, k) * l2);
   endfunction

   function automatic longint clip(longint v, longint lim);
      if (v > lim)
         return lim;
      if (v < -lim)
         return -lim;
      return v;
   endfunction

   function automatic lgq_result_type eval_legendre_q(logic [31:0] raw, logic [5:0] deg);
      longint x, n, k, l_prev, l_cur, l_old, d_prev, d_cur, d_old, l_next, d_next;
      lgq_result_type r;
      x = clip(longint'($signed(raw)), ONE_Q30);
      n = longint'(deg);
      if (n < 1)
         n = 1;
      if (n > MAX_DEGREE)
         n = MAX_DEGREE;
      l_prev = ONE_Q30;
      l_cur  = x;
      d_prev = 0;
      d_cur  = ONE_Q30;
      for (k = 2; k <= n; k++) begin
         l_old  = l_prev;
         d_old  = d_prev;
         l_prev = l_cur;
         d_prev = d_cur;
         l_cur  = next_legendre(k, x, l_prev, l_old);
         d_cur  = d_old + (2 * k - 1) * l_prev;
      end
      l_next = next_legendre(n + 1, x, l_cur, l_prev);
      d_next = d_prev + (2 * (n + 1) - 1) * l_cur;
      r.legendre_value = 32'(clip(l_cur, ONE_Q30));
      r.q_value        = 33'(clip(l_next - l_prev, 2 * ONE_Q30));
      r.q_slope        = 38'(clip(d_next - d_prev, 65 * ONE_Q30));
      return r;
   endfunction

   task automatic compare_field(string what, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, what, want, got);
      end
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
      degree_now = 6'd1;
   end

   always @(posedge clock) begin
      lgq_result_type want, got;
      if (reset) begin
         degree_now = 6'd1;
         predicted_evals.delete();
         pending = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = lgq_result_type'(rsp_tdata[102:0]);
            if (predicted_evals.size() == 0) begin
               fail_count++;
               $display("%0t ns: unexpected item, expected none, actual %h", $time, rsp_tdata);
            end else begin
               want = predicted_evals.pop_front();
               compare_field("legendre_value", want.legendre_value, got.legendre_value);
               compare_field("q_value", want.q_value, got.q_value);
               compare_field("q_slope", want.q_slope, got.q_slope);
            end
         end
         // degree in force at the edge applies to an item taken at that edge
         if (req_tvalid && req_tready)
            predicted_evals.push_back(eval_legendre_q(req_tdata, degree_now));
         if (csr_wr_en)
            degree_now = csr_wr_data;
         pending = predicted_evals.size();
      end
   end

endmodule

FILE: test/legendre_q_and_value_eval_tb.sv
`timescale 1ns / 1ps

module legendre_q_and_value_eval_tb;

   import lgq_pkg::*;

   localparam int MAX_DEGREE  = 32;
   localparam int LATENCY     = 2 * MAX_DEGREE + 3;
   localparam int HOLD_CYCLES = 400;
   localparam int WATCH_LIMIT = 4000;
   localparam int NUM_PHASES  = 8;

   logic         clock;
   logic         reset;
   logic         csr_wr_en;
   logic [5:0]   csr_wr_data;
   logic         req_tvalid;
   logic         req_tready;
   logic [31:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;

   int  fail_count;
   int  pending;
   int  idle_pct;
   int  stall_pct;
   int  quiet_cycles;
   bit  long_hold;
   logic req_taken;

   // -1 picks a random degree
   int phase_degree[NUM_PHASES] = '{2, 32, 5, -1, 32, 1, -1, 63};
   int phase_idle[NUM_PHASES]   = '{0, 65, 0, 30, 0, 30, 0, 0};
   int phase_stall[NUM_PHASES]  = '{0, 0, 65, 30, 0, 30, 0, 65};
   int phase_items[NUM_PHASES]  = '{100, 100, 100, 100, 150, 80, 60, 60};

   legendre_q_and_value_eval #(.MAX_DEGREE(MAX_DEGREE)) DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   legendre_eval_check #(.MAX_DEGREE(MAX_DEGREE)) eval_check (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCH_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls, or one long hold-off on request
   initial begin
      bit hold_done;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_point(input logic [31:0] pt);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pt;
      do @(negedge clock); while (!req_taken);
   endtask

   task automatic set_degree(input logic [5:0] deg);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 8) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= deg;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [31:0] rand_point();
      case ($urandom_range(9))
         0: return $urandom;
         1: return ($urandom_range(1) ? 32'h4000_0000 : 32'hC000_0000)
                   + 32'($urandom_range(8)) - 32'd4;
         default: return 32'($urandom_range(32'h8000_0000)) - 32'h4000_0000;
      endcase
   endfunction

   initial begin
      logic [31:0] edge_points[11];
      int p, i;
      edge_points = '{32'h0000_0000, 32'h4000_0000, 32'hC000_0000, 32'h0000_0001,
                      32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h4000_0001,
                      32'hBFFF_FFFF, 32'h2000_0000, 32'hE000_0000};
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = 6'd0;
      req_tvalid  = 1'b0;
      req_tdata   = 32'd0;
      idle_pct    = 0;
      stall_pct   = 0;
      long_hold   = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // degree one out of reset, then zero, all ones, the maximum and one past it
      foreach (edge_points[i])
         send_point(edge_points[i]);
      set_degree(6'd0);
      for (i = 0; i < 3; i++)
         send_point(edge_points[i]);
      set_degree(6'd63);
      for (i = 0; i < 4; i++)
         send_point(edge_points[i + 1]);
      set_degree(6'd32);
      for (i = 0; i < 4; i++)
         send_point(edge_points[i]);
      set_degree(6'd33);
      send_point(edge_points[9]);
      send_point(edge_points[10]);

      for (p = 0; p < NUM_PHASES; p++) begin
         set_degree(phase_degree[p] < 0 ? 6'($urandom_range(63)) : 6'(phase_degree[p]));
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         // receiver holds off while the sender keeps the input full
         if (p == 4)
            long_hold = 1'b1;
         for (i = 0; i < phase_items[p]; i++)
            send_point(rand_point());
      end

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 8) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
src/lgq_pkg.sv
src/lgq_step.sv
src/lgq_finish.sv
src/lgq_outbuf.sv
src/legendre_q_and_value_eval.sv
test/legendre_eval_check.sv
test/legendre_q_and_value_eval_tb.sv
